>>> src/rcfd_pkg.sv
// Package for the RIFF chunk frame demultiplexer.
// Holds the transfer structs, chunk constants and queue sizing; depends on nothing.
package rcfd_pkg;

    localparam int unsigned SIZE_BITS_DEF = 32;
    localparam int unsigned FRAME_W       = 17;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam logic [31:0]      LIST_ID          = 32'h5453_494C;
    localparam logic [31:0]      TARGET_ID_RESET  = 32'h6364_3030;
    localparam logic [FRAME_W-1:0] FRAME_LIMIT_RESET = 17'h1_0000;
    localparam logic [2:0]       LIST_TYPE_BYTES  = 3'd4;
    localparam logic [2:0]       HDR_LAST_COUNT   = 3'd7;

    localparam logic REG_FRAME_LIMIT = 1'b0;
    localparam logic REG_TARGET_ID   = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_last;
    } t_in;

    typedef struct packed {
        logic [7:0]         payload_byte;
        logic               frame_first;
        logic               frame_last;
        logic [FRAME_W-1:0] frame_size;
        logic               keyframe;
        logic               truncated;
    } t_out;

endpackage

>>> src/rcfd_parser.sv
// Front part: walks the chunk headers byte by byte and classifies each byte.
// Emits one result struct per payload byte of a matching chunk; uses rcfd_pkg.
module rcfd_parser import rcfd_pkg::*; #(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_in                i_item,
    input  logic [FRAME_W-1:0] i_frame_limit,
    input  logic [31:0]        i_target_id,
    output logic               o_valid,
    output t_out               o_result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [2:0]           r_cnt, n_cnt;
    logic [55:0]          r_hdr, n_hdr;
    logic [SIZE_BITS-1:0] r_rem, n_rem;
    logic                 r_pad, n_pad;
    logic                 r_key, n_key;
    logic [FRAME_W-1:0]   r_cur, n_cur;

    logic [63:0]          hdr_full;
    logic [31:0]          hdr_id;
    logic [SIZE_BITS-1:0] hdr_size;
    logic                 rem_end;
    logic                 is_first;

    assign hdr_full = {i_item.data_byte, r_hdr};
    assign hdr_id   = hdr_full[31:0];
    assign hdr_size = hdr_full[32 +: SIZE_BITS];
    assign rem_end  = (r_rem <= SIZE_BITS'(1));
    assign is_first = (r_rem == SIZE_BITS'(r_cur));

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_hdr    = r_hdr;
        n_rem    = r_rem;
        n_pad    = r_pad;
        n_key    = r_key;
        n_cur    = r_cur;
        o_valid  = 1'b0;
        o_result = '0;

        unique case (r_phase)
            PH_HEADER: begin
                n_hdr = {i_item.data_byte, r_hdr[55:8]};
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == HDR_LAST_COUNT) begin
                    if (hdr_id == LIST_ID) begin
                        n_rem   = SIZE_BITS'(LIST_TYPE_BYTES);
                        n_pad   = 1'b0;
                        n_phase = PH_SKIP;
                    end else if (hdr_id == i_target_id && hdr_size != '0 &&
                                 hdr_size <= SIZE_BITS'(i_frame_limit)) begin
                        n_pad   = hdr_size[0];
                        n_cur   = hdr_size[FRAME_W-1:0];
                        n_rem   = hdr_size;
                        n_phase = PH_PAYLOAD;
                    end else if (hdr_size == '0) begin
                        n_pad   = 1'b0;
                        n_phase = PH_HEADER;
                    end else begin
                        n_pad   = hdr_size[0];
                        n_rem   = hdr_size;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_valid               = i_accept;
                o_result.payload_byte = i_item.data_byte;
                o_result.frame_first  = is_first;
                o_result.frame_last   = rem_end || i_item.region_last;
                o_result.frame_size   = r_cur;
                o_result.keyframe     = r_key;
                o_result.truncated    = i_item.region_last && !rem_end;
                if (rem_end) begin
                    n_key = 1'b0;
                    n_cur = '0;
                    if (r_pad) begin
                        n_pad   = 1'b0;
                        n_rem   = SIZE_BITS'(1);
                        n_phase = PH_SKIP;
                    end else begin
                        n_rem   = '0;
                        n_phase = PH_HEADER;
                    end
                end else begin
                    n_rem = r_rem - SIZE_BITS'(1);
                end
            end
            PH_SKIP: begin
                if (rem_end) begin
                    if (r_pad) begin
                        n_pad   = 1'b0;
                        n_rem   = SIZE_BITS'(1);
                        n_phase = PH_SKIP;
                    end else begin
                        n_rem   = '0;
                        n_phase = PH_HEADER;
                    end
                end else begin
                    n_rem = r_rem - SIZE_BITS'(1);
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        if (i_item.region_last) begin
            n_phase = PH_HEADER;
            n_cnt   = '0;
            n_hdr   = '0;
            n_rem   = '0;
            n_pad   = 1'b0;
            n_key   = 1'b1;
            n_cur   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt   <= '0;
            r_hdr   <= '0;
            r_rem   <= '0;
            r_pad   <= 1'b0;
            r_key   <= 1'b1;
            r_cur   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hdr   <= n_hdr;
            r_rem   <= n_rem;
            r_pad   <= n_pad;
            r_key   <= n_key;
            r_cur   <= n_cur;
        end
    end

endmodule

>>> src/rcfd_queue.sv
// Back part: a short queue that holds classified payload bytes until taken.
// The depth comes from rcfd_pkg and must be a power of two.
module rcfd_queue import rcfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_out i_wdata,
    input  logic i_rd,
    output logic o_full,
    output logic o_empty,
    output t_out o_rdata
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_out             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> src/riff_chunk_frame_demux.sv
// Top level of the RIFF chunk frame demultiplexer: configuration registers,
// parser front part and result queue; uses rcfd_pkg, rcfd_parser and rcfd_queue.
//
//  Channel   Handshake                        Payload
//  input     push / full                      i_data  (t_in: data_byte, region_last)
//  result    pop / empty                      o_data  (t_out: payload byte and flags)
//  config    psel, penable, pwrite, pready    paddr[2] selects register, pwdata / prdata
//
// One byte is taken per cycle while full is low; a payload byte reaches the result
// side in the cycle after its transfer, and other bytes produce nothing.
// The result queue holds four entries; full rises only when the result side stalls.
// Reset is synchronous and puts the parser, queue and registers in their reset state.
// frame_limit sits at address 0 and target_id at address 4.
module riff_chunk_frame_demux import rcfd_pkg::*; #(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in         i_data,
    input  logic        pop,
    output logic        empty,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [FRAME_W-1:0] r_frame_limit;
    logic [31:0]        r_target_id;
    logic               cfg_wr;
    logic               in_accept;
    logic               res_valid;
    t_out               res_item;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign in_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RESET;
            r_target_id   <= TARGET_ID_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_LIMIT: r_frame_limit <= pwdata[FRAME_W-1:0];
                REG_TARGET_ID:   r_target_id   <= pwdata;
                default:         r_target_id   <= r_target_id;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_LIMIT: prdata = 32'(r_frame_limit);
            REG_TARGET_ID:   prdata = r_target_id;
            default:         prdata = '0;
        endcase
    end

    rcfd_parser #(
        .SIZE_BITS(SIZE_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_data),
        .i_frame_limit(r_frame_limit),
        .i_target_id  (r_target_id),
        .o_valid      (res_valid),
        .o_result     (res_item)
    );

    rcfd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (res_valid),
        .i_wdata(res_item),
        .i_rd   (pop),
        .o_full (full),
        .o_empty(empty),
        .o_rdata(o_data)
    );

endmodule

>>> verif/tb_riff_chunk_frame_demux.sv
`timescale 1ns / 1ps
// Self-checking testbench for riff_chunk_frame_demux: drives movi region bytes through
// the push/full side and checks every payload transfer against a byte-level chunk parser.
// Depends on rcfd_pkg and the riff_chunk_frame_demux RTL; reads no files.
module tb_riff_chunk_frame_demux;
    import rcfd_pkg::*;

    typedef enum logic [1:0] {HDR_GATHER, PAYLOAD_OUT, BYTE_SKIP} t_parse_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_last;
        logic       typed;
        t_out       res;
    } t_stim_row;

    localparam logic [2:0]  ADDR_FRAME_LIMIT = {REG_FRAME_LIMIT, 2'b00};
    localparam logic [2:0]  ADDR_TARGET_ID   = {REG_TARGET_ID, 2'b00};
    localparam logic [31:0] SIZE_MASK        = 32'((64'd1 << SIZE_BITS_DEF) - 64'd1);
    localparam int          NUM_SETTINGS     = 7;
    localparam int unsigned BYTES_PER_SETTING = 210;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    t_in         i_data  = '0;
    logic        pop     = 1'b0;
    logic        empty;
    t_out        o_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    riff_chunk_frame_demux uut (
        .i_clk, .i_rst_n, .push, .full, .i_data, .pop, .empty, .o_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #2 i_clk = ~i_clk;

    // Parser state and register copies.
    t_parse_phase       ph;
    logic [2:0]         hdr_cnt;
    logic [63:0]        hdr_word;
    logic [31:0]        remaining;
    logic               pad_pend;
    logic               key_pend;
    logic [FRAME_W-1:0] cur_size;
    logic [FRAME_W-1:0] lim_reg;
    logic [31:0]        id_reg;

    t_out        frame_q [$];
    logic [7:0]  region_q [$];
    t_stim_row   dir_rows [32];

    int unsigned fail_count   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned regions_sent = 0;
    int unsigned results_seen = 0;
    int unsigned key_seen     = 0;
    int unsigned trunc_seen   = 0;
    int unsigned tx_quiet     = 0;
    int unsigned rx_quiet     = 0;
    int unsigned rx_stall     = 0;
    bit          hold_req     = 1'b0;

    function automatic void restart_parser();
        ph = HDR_GATHER;
        hdr_cnt = '0;
        hdr_word = '0;
        remaining = '0;
        pad_pend = 1'b0;
        key_pend = 1'b1;
        cur_size = '0;
    endfunction

    function automatic void finish_body();
        if (pad_pend) begin
            pad_pend = 1'b0;
            remaining = 32'd1;
            ph = BYTE_SKIP;
        end else begin
            ph = HDR_GATHER;
        end
    endfunction

    function automatic void decode_header();
        logic [31:0] id;
        logic [31:0] sz;
        id = hdr_word[31:0];
        sz = hdr_word[63:32] & SIZE_MASK;
        hdr_cnt = '0;
        hdr_word = '0;
        if (id == LIST_ID) begin
            remaining = 32'(LIST_TYPE_BYTES);
            pad_pend = 1'b0;
            ph = BYTE_SKIP;
        end else begin
            pad_pend = sz[0];
            if (id == id_reg && sz != 0 && sz <= 32'(lim_reg)) begin
                cur_size = sz[FRAME_W-1:0];
                remaining = sz;
                ph = PAYLOAD_OUT;
            end else if (sz == 0) begin
                finish_body();
            end else begin
                remaining = sz;
                ph = BYTE_SKIP;
            end
        end
    endfunction

    function automatic void parse_byte(input t_in v, output bit made, output t_out res);
        logic at_end;
        logic cut;
        made = 1'b0;
        res = '0;
        case (ph)
            HDR_GATHER: begin
                hdr_word = hdr_word | (64'(v.data_byte) << {hdr_cnt, 3'b000});
                hdr_cnt = hdr_cnt + 3'd1;
                if (hdr_cnt == 3'd0) decode_header();
            end
            PAYLOAD_OUT: begin
                at_end = (remaining <= 32'd1);
                cut = v.region_last && !at_end;
                res.payload_byte = v.data_byte;
                res.frame_first = (remaining == 32'(cur_size));
                res.frame_last = at_end || cut;
                res.frame_size = cur_size;
                res.keyframe = key_pend;
                res.truncated = cut;
                made = 1'b1;
                if (at_end) begin
                    remaining = '0;
                    key_pend = 1'b0;
                    cur_size = '0;
                    finish_body();
                end else begin
                    remaining = remaining - 32'd1;
                end
            end
            default: begin
                if (remaining <= 32'd1) begin
                    remaining = '0;
                    finish_body();
                end else begin
                    remaining = remaining - 32'd1;
                end
            end
        endcase
        if (v.region_last) restart_parser();
    endfunction

    function automatic t_stim_row plain_row(input logic [7:0] b, input logic lst);
        t_stim_row r;
        r = '0;
        r.data_byte = b;
        r.region_last = lst;
        return r;
    endfunction

    function automatic t_stim_row typed_row(input logic [7:0] b, input logic lst,
                                            input logic fst, input logic lstf,
                                            input logic [FRAME_W-1:0] sz,
                                            input logic key, input logic trn);
        t_stim_row r;
        r = plain_row(b, lst);
        r.typed = 1'b1;
        r.res.payload_byte = b;
        r.res.frame_first = fst;
        r.res.frame_last = lstf;
        r.res.frame_size = sz;
        r.res.keyframe = key;
        r.res.truncated = trn;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR: %s", msg);
    endfunction

    function automatic string fmt_res(input t_out r);
        return $sformatf("byte=%h first=%b last=%b size=%0d key=%b trunc=%b", r.payload_byte,
                         r.frame_first, r.frame_last, r.frame_size, r.keyframe, r.truncated);
    endfunction

    function automatic void check_result(input t_out got);
        t_out want;
        if (frame_q.size() == 0) begin
            note_failure($sformatf("unexpected transfer: %s", fmt_res(got)));
        end else begin
            want = frame_q.pop_front();
            if (got.payload_byte !== want.payload_byte || got.frame_first !== want.frame_first ||
                got.frame_last !== want.frame_last || got.frame_size !== want.frame_size ||
                got.keyframe !== want.keyframe || got.truncated !== want.truncated) begin
                note_failure($sformatf("result %0d expected %s got %s", results_seen,
                                       fmt_res(want), fmt_res(got)));
            end
        end
        results_seen++;
        if (got.keyframe === 1'b1) key_seen++;
        if (got.truncated === 1'b1) trunc_seen++;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int unsigned idle_len(inout int unsigned quiet, input int unsigned long_max);
        int unsigned r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) quiet = $urandom_range(30, 150);
        if (r < 72) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, long_max);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_result(o_data);
            if (hold_req) begin
                hold_req = 1'b0;
                rx_stall = 80;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                rx_stall = idle_len(rx_quiet, 40);
            end
        end
    end

    task automatic send_byte(input t_in v, input bit typed, input t_out typed_res);
        t_out res;
        bit   made;
        push <= 1'b1;
        i_data <= v;
        do @(posedge i_clk); while (full !== 1'b0);
        parse_byte(v, made, res);
        if (typed) frame_q.push_back(typed_res);
        else if (made) frame_q.push_back(res);
        bytes_sent++;
    endtask

    task automatic pace_input();
        int unsigned g;
        g = idle_len(tx_quiet, 30);
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_region();
        t_in v;
        foreach (region_q[k]) begin
            v.data_byte = region_q[k];
            v.region_last = (k == region_q.size() - 1);
            send_byte(v, 1'b0, '0);
            pace_input();
        end
        regions_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_regs(input logic [FRAME_W-1:0] lim, input logic [31:0] id);
        logic [31:0] rd;
        apb_read(ADDR_FRAME_LIMIT, rd);
        if (rd !== 32'(lim)) note_failure($sformatf("frame_limit read %h, expected %h", rd, lim));
        apb_read(ADDR_TARGET_ID, rd);
        if (rd !== id) note_failure($sformatf("target_id read %h, expected %h", rd, id));
    endtask

    task automatic set_config(input logic [FRAME_W-1:0] lim, input logic [31:0] id);
        wait_drained();
        apb_write(ADDR_FRAME_LIMIT, {15'($urandom), lim});
        lim_reg = lim;
        apb_write(ADDR_TARGET_ID, id);
        id_reg = id;
        check_regs(lim, id);
    endtask

    function automatic void put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) region_q.push_back(w[8*k +: 8]);
    endfunction

    function automatic void put_body(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) region_q.push_back(8'($urandom));
        if (n[0]) region_q.push_back(8'($urandom));
    endfunction

    // A region is a few well-formed chunks with random content; some regions end in
    // the middle of a chunk or carry plain noise.
    function automatic void make_region();
        int unsigned nch;
        int unsigned kind;
        int unsigned sz;
        int unsigned cut;
        bit          open_end;
        region_q.delete();
        open_end = 1'b0;
        nch = $urandom_range(1, 4);
        for (int unsigned c = 0; c < nch && !open_end; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                put_word(id_reg);
                put_word(sz);
                put_body(sz);
            end else if (kind < 58) begin
                sz = $urandom_range(0, 9);
                put_word($urandom);
                put_word(sz);
                put_body(sz);
            end else if (kind < 68) begin
                put_word(LIST_ID);
                put_word($urandom);
                put_word($urandom);
            end else if (kind < 73) begin
                put_word(id_reg);
                put_word(32'd0);
            end else if (kind < 80) begin
                sz = lim_reg + $urandom_range(1, 3);
                put_word(id_reg);
                put_word(sz);
                if (sz <= 48) begin
                    put_body(sz);
                end else begin
                    put_body($urandom_range(0, 8));
                    open_end = 1'b1;
                end
            end else if (kind < 88) begin
                put_word($urandom_range(0, 1) ? id_reg : $urandom);
                put_word($urandom_range(0, 1) ? 32'(lim_reg) : $urandom);
                put_body($urandom_range(0, 8));
                open_end = 1'b1;
            end else begin
                put_body($urandom_range(1, 6));
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, region_q.size());
            while (region_q.size() > cut) void'(region_q.pop_back());
        end
    endfunction

    initial begin
        logic [FRAME_W-1:0] lim_set [NUM_SETTINGS];
        logic [31:0]        id_set [NUM_SETTINGS];
        int unsigned        cnt;

        restart_parser();
        lim_reg = FRAME_LIMIT_RESET;
        id_reg = TARGET_ID_RESET;
        lim_set = '{FRAME_LIMIT_RESET, 17'd1, 17'd0, 17'h1_FFFF, 17'd7,
                    FRAME_W'($urandom_range(2, 40)), FRAME_LIMIT_RESET};
        id_set = '{TARGET_ID_RESET, TARGET_ID_RESET, 32'd0, 32'hFFFF_FFFF, LIST_ID,
                   $urandom, TARGET_ID_RESET};
        // Odd target frame cut by the region end, a LIST header with its type,
        // then a one-byte keyframe whose pad byte closes the region.
        dir_rows = '{
            plain_row(8'h30, 1'b0), plain_row(8'h30, 1'b0),
            plain_row(8'h64, 1'b0), plain_row(8'h63, 1'b0),
            plain_row(8'h03, 1'b0), plain_row(8'h00, 1'b0),
            plain_row(8'h00, 1'b0), plain_row(8'h00, 1'b0),
            typed_row(8'h00, 1'b0, 1'b1, 1'b0, 17'd3, 1'b1, 1'b0),
            typed_row(8'hFF, 1'b1, 1'b0, 1'b1, 17'd3, 1'b1, 1'b1),
            plain_row(8'h4C, 1'b0), plain_row(8'h49, 1'b0),
            plain_row(8'h53, 1'b0), plain_row(8'h54, 1'b0),
            plain_row(8'hFF, 1'b0), plain_row(8'hFF, 1'b0),
            plain_row(8'hFF, 1'b0), plain_row(8'hFF, 1'b0),
            plain_row(8'h6D, 1'b0), plain_row(8'h6F, 1'b0),
            plain_row(8'h76, 1'b0), plain_row(8'h69, 1'b0),
            plain_row(8'h30, 1'b0), plain_row(8'h30, 1'b0),
            plain_row(8'h64, 1'b0), plain_row(8'h63, 1'b0),
            plain_row(8'h01, 1'b0), plain_row(8'h00, 1'b0),
            plain_row(8'h00, 1'b0), plain_row(8'h00, 1'b0),
            typed_row(8'h80, 1'b0, 1'b1, 1'b1, 17'd1, 1'b1, 1'b0),
            plain_row(8'h00, 1'b1)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_regs(FRAME_LIMIT_RESET, TARGET_ID_RESET);

        foreach (dir_rows[k]) begin
            send_byte('{data_byte: dir_rows[k].data_byte, region_last: dir_rows[k].region_last},
                      dir_rows[k].typed, dir_rows[k].res);
            pace_input();
        end

        // The result side holds off while a long frame keeps coming, so the queue fills.
        wait_drained();
        hold_req = 1'b1;
        tx_quiet = 80;
        region_q.delete();
        put_word(id_reg);
        put_word(32'd60);
        put_body(60);
        send_region();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            set_config(lim_set[p], id_set[p]);
            cnt = 0;
            while (cnt < BYTES_PER_SETTING) begin
                make_region();
                cnt += region_q.size();
                send_region();
            end
        end

        push <= 1'b0;
        cnt = 0;
        while (frame_q.size() != 0 && cnt < 20000) begin
            @(posedge i_clk);
            cnt++;
        end
        repeat (16) @(posedge i_clk);
        if (frame_q.size() != 0)
            note_failure($sformatf("%0d expected transfers never arrived", frame_q.size()));

        $display("Sent %0d movi bytes in %0d regions over %0d register settings.",
                 bytes_sent, regions_sent, NUM_SETTINGS + 1);
        $display("Checked %0d payload transfers: %0d keyframe bytes, %0d truncated frame ends.",
                 results_seen, key_seen, trunc_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
